>>> sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation, status and compare codes and the default value width.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_CMP = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMP_LESS    = 2'd0,
		CMP_EQUAL   = 2'd1,
		CMP_GREATER = 2'd2
	} cmp_t;

endpackage

>>> sv/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact fraction add, subtract, multiply, divide
// and compare, with the result reduced by a binary gcd.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   a_num[31:0] a_den[63:32] b_num b_den       mode[2:0]
// m_axis   out  res_num[31:0] res_den[62:32] 0[63]          cmp[1:0] status[3:2]
//
// After a beat is taken: the four products on one shared signed
// (VW+1)-by-(VW+1) multiplier (S_MUL), the sum (S_SUM), the binary gcd
// (S_GCD, one shift or subtract a cycle), each of the two quotients by a
// shared restoring divider (S_DIVN, S_DIVD), the range check (S_FIN) and the
// load of the output register (S_OUT), which waits while that register is
// still full. Compare goes from S_SUM to S_OUT, the error cases and unused
// modes from idle. A new beat is taken only in idle. Reset clears the sequencer.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// a_numerator, a_denominator, b_numerator, b_denominator
	input  logic [127:0] s_axis_tdata,
	// mode
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_numerator, result_denominator, zero fill
	output logic [63:0]  m_axis_tdata,
	// compare_result, status
	output logic [3:0]   m_axis_tuser
);

	localparam int VW = VALUE_WIDTH;
	localparam int WW = 2 * VW + 1;       // working width, holds any sum
	localparam int CW = $clog2(WW + 2);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_MUL  = 8'b00000010,
		S_SUM  = 8'b00000100,
		S_GCD  = 8'b00001000,
		S_DIVN = 8'b00010000,
		S_DIVD = 8'b00100000,
		S_FIN  = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t state_q;
	logic [2:0] mode_q;
	logic signed [VW:0] an_q, ad_q, bn_q, bd_q;
	logic [1:0] mstep_q;
	logic signed [2*VW+1:0] prod;
	logic signed [2*VW+1:0] p_q, q_q;
	logic [WW-1:0] n_q, d_q, gx_q, gy_q, g_q;
	logic [CW-1:0] sh_q;
	logic neg_q;
	// divider
	logic [WW-1:0] dv_rem_q, dv_quo_q;
	logic [CW-1:0] dv_cnt_q;
	logic [CW-1:0] dv_idx;
	logic [WW-1:0] dv_num;
	logic [WW:0]   dv_trial;
	logic [WW-1:0] qn_q;
	// finished result
	logic [VW-1:0] rn_q;
	logic [VW-2:0] rd_q;
	logic [1:0] cmp_q, st_q;
	// output register
	logic        m_valid_q;
	logic [63:0] m_data_q;
	logic [3:0]  m_user_q;
	logic        out_load;

	// Operand sign extension from bit VW-1.
	function automatic logic signed [VW:0] sx(input logic [31:0] v);
		logic [VW-1:0] t;
		t = v[VW-1:0];
		sx = {t[VW-1], t};
	endfunction

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;

	// The finished result moves on once the output register is free.
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q <= '0;
			m_user_q <= '0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
			m_data_q <= {1'b0, 31'(rd_q), 32'($signed(rn_q))};
			m_user_q <= {st_q, cmp_q};
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Shared multiplier: one product per cycle selected by the step.
	logic signed [VW:0] ma, mb;
	always_comb begin
		ma = an_q;
		mb = bd_q;
		case (mstep_q)
			2'd0: begin ma = an_q; mb = bd_q; end
			2'd1: begin ma = bn_q; mb = ad_q; end
			2'd2: begin ma = ad_q; mb = bd_q; end
			default: begin ma = an_q; mb = bn_q; end
		endcase
	end
	assign prod = (2*VW+2)'(ma) * (2*VW+2)'(mb);

	// Divider step: remainder shifted left with the next dividend bit.
	assign dv_num = (state_q == S_DIVN) ? n_q : d_q;
	assign dv_idx = CW'(WW - 1) - dv_cnt_q;
	assign dv_trial = {dv_rem_q, dv_num[dv_idx]} - {1'b0, g_q};

	function automatic logic [WW-1:0] mag(input logic signed [2*VW+1:0] x);
		logic signed [2*VW+1:0] t;
		t = x[2*VW+1] ? -x : x;
		mag = t[WW-1:0];
	endfunction

	logic [WW-1:0] lim;
	assign lim = WW'(1) << (VW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						logic signed [VW:0] an, ad, bn, bd;
						an = sx(s_axis_tdata[31:0]);
						ad = sx(s_axis_tdata[63:32]);
						bn = sx(s_axis_tdata[95:64]);
						bd = sx(s_axis_tdata[127:96]);
						mode_q <= s_axis_tuser;
						rn_q <= '0;
						rd_q <= '0;
						cmp_q <= rau_pkg::CMP_EQUAL;
						st_q <= rau_pkg::ST_OK;
						mstep_q <= 2'd0;
						an_q <= ad[VW] ? -an : an;
						ad_q <= ad[VW] ? -ad : ad;
						bn_q <= bd[VW] ? -bn : bn;
						bd_q <= bd[VW] ? -bd : bd;
						if (s_axis_tuser > 3'(rau_pkg::OP_CMP)) begin
							state_q <= S_OUT;
						end else if (ad == '0 || bd == '0) begin
							st_q <= rau_pkg::ST_ZERO_DEN;
							state_q <= S_OUT;
						end else if (s_axis_tuser == 3'(rau_pkg::OP_DIV) && bn == '0) begin
							st_q <= rau_pkg::ST_DIV_ZERO;
							state_q <= S_OUT;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					case (mstep_q)
						2'd0: p_q <= prod;
						2'd1: q_q <= prod;
						2'd2: d_q <= mag(prod);
						default: begin
							// a*b numerator for multiply; divide uses p and q
							if (mode_q == 3'(rau_pkg::OP_MUL)) p_q <= prod;
							state_q <= S_SUM;
						end
					endcase
				end
				S_SUM: begin
					logic signed [2*VW+1:0] s;
					case (mode_q)
						3'(rau_pkg::OP_ADD): s = p_q + q_q;
						3'(rau_pkg::OP_SUB): s = p_q - q_q;
						default: s = p_q;
					endcase
					if (mode_q == 3'(rau_pkg::OP_CMP)) begin
						cmp_q <= (p_q < q_q) ? rau_pkg::CMP_LESS :
							(p_q == q_q) ? rau_pkg::CMP_EQUAL : rau_pkg::CMP_GREATER;
						state_q <= S_OUT;
					end else begin
						if (mode_q == 3'(rau_pkg::OP_DIV)) begin
							// a/b = (an*bd)/(ad*bn), sign from an and bn
							neg_q <= p_q[2*VW+1] ^ q_q[2*VW+1];
							n_q <= mag(p_q);
							d_q <= mag(q_q);
							gx_q <= mag(p_q);
							gy_q <= mag(q_q);
						end else begin
							neg_q <= s[2*VW+1];
							n_q <= mag(s);
							gx_q <= mag(s);
							gy_q <= d_q;
						end
						sh_q <= '0;
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					// Binary gcd, one step per cycle.
					if (gx_q == '0) begin
						g_q <= gy_q << sh_q;
						dv_rem_q <= '0; dv_quo_q <= '0; dv_cnt_q <= '0;
						state_q <= S_DIVN;
					end else if (gy_q == '0) begin
						g_q <= gx_q << sh_q;
						dv_rem_q <= '0; dv_quo_q <= '0; dv_cnt_q <= '0;
						state_q <= S_DIVN;
					end else if (!gx_q[0] && !gy_q[0]) begin
						gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; sh_q <= sh_q + 1'b1;
					end else if (!gx_q[0]) begin
						gx_q <= gx_q >> 1;
					end else if (!gy_q[0]) begin
						gy_q <= gy_q >> 1;
					end else if (gx_q >= gy_q) begin
						gx_q <= (gx_q - gy_q) >> 1;
					end else begin
						gy_q <= (gy_q - gx_q) >> 1;
					end
				end
				S_DIVN, S_DIVD: begin
					// Restoring division by the gcd, one quotient bit a cycle.
					logic [WW-1:0] q_next;
					logic [WW-1:0] r_next;
					if (!dv_trial[WW]) begin
						r_next = dv_trial[WW-1:0];
						q_next = {dv_quo_q[WW-2:0], 1'b1};
					end else begin
						r_next = {dv_rem_q[WW-2:0], dv_num[dv_idx]};
						q_next = {dv_quo_q[WW-2:0], 1'b0};
					end
					if (dv_cnt_q == CW'(WW - 1)) begin
						dv_cnt_q <= '0;
						dv_rem_q <= '0;
						dv_quo_q <= '0;
						if (state_q == S_DIVN) begin
							qn_q <= q_next;
							state_q <= S_DIVD;
						end else begin
							d_q <= q_next;
							n_q <= qn_q;
							state_q <= S_FIN;
						end
					end else begin
						dv_cnt_q <= dv_cnt_q + 1'b1;
						dv_rem_q <= r_next;
						dv_quo_q <= q_next;
					end
				end
				S_FIN: begin
					logic ng;
					ng = neg_q && (n_q != '0);
					if (d_q > lim - 1'b1 || (ng ? n_q > lim : n_q > lim - 1'b1)) begin
						st_q <= rau_pkg::ST_OVERFLOW;
					end else begin
						logic [WW-1:0] sn;
						sn = ng ? -n_q : n_q;
						rn_q <= sn[VW-1:0];
						rd_q <= d_q[VW-2:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> tb/rational_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test: self-checking bench for the fraction unit
// Drives operand beats with random gaps, predicts each reduced result with
// 64-bit arithmetic and a Euclid gcd, and checks every result beat in order.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [1:0]  status;
	logic [1:0]  cmp;
	logic [30:0] den;
	logic [31:0] num;
} frac_result_t;

class fraction_scoreboard;
	frac_result_t pending[$];
	int mismatches;

	function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Reduce a signed-magnitude fraction and apply the 32-bit range check.
	function frac_result_t reduce(bit neg, logic [63:0] n, logic [63:0] d);
		frac_result_t r;
		logic [63:0] g;
		logic [63:0] lim;
		lim = 64'd1 << 31;
		g = gcd64(n, d);
		n = n / g;
		d = d / g;
		if (n == 0) neg = 0;
		r = '0;
		r.cmp = rau_pkg::CMP_EQUAL;
		if (d > lim - 1 || (neg ? n > lim : n > lim - 1)) begin
			r.status = rau_pkg::ST_OVERFLOW;
		end else begin
			r.num = neg ? -n[31:0] : n[31:0];
			r.den = d[30:0];
			r.status = rau_pkg::ST_OK;
		end
		return r;
	endfunction

	function void note_operands(logic [2:0] mode, logic [127:0] data);
		longint an, ad, bn, bd, p, q;
		logic [63:0] n, d, mp, mq;
		bit neg, np, nq;
		frac_result_t r;
		an = $signed(data[31:0]);
		ad = $signed(data[63:32]);
		bn = $signed(data[95:64]);
		bd = $signed(data[127:96]);
		r = '0;
		r.cmp = rau_pkg::CMP_EQUAL;
		r.status = rau_pkg::ST_OK;
		if (mode <= rau_pkg::OP_CMP) begin
			if (ad == 0 || bd == 0) begin
				r.status = rau_pkg::ST_ZERO_DEN;
			end else begin
				if (ad < 0) begin ad = -ad; an = -an; end
				if (bd < 0) begin bd = -bd; bn = -bn; end
				case (mode)
					rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
						p = an * bd;
						q = bn * ad;
						np = p < 0;
						nq = (q < 0) != (mode == rau_pkg::OP_SUB);
						mp = p < 0 ? -p : p;
						mq = q < 0 ? -q : q;
						if (np == nq) begin neg = np; n = mp + mq; end
						else if (mp >= mq) begin neg = np; n = mp - mq; end
						else begin neg = nq; n = mq - mp; end
						r = reduce(neg, n, ad * bd);
					end
					rau_pkg::OP_MUL: begin
						neg = (an < 0) != (bn < 0);
						n = (an < 0 ? -an : an) * (bn < 0 ? -bn : bn);
						r = reduce(neg, n, ad * bd);
					end
					rau_pkg::OP_DIV: begin
						if (bn == 0) begin
							r.status = rau_pkg::ST_DIV_ZERO;
						end else begin
							neg = (an < 0) != (bn < 0);
							n = (an < 0 ? -an : an) * bd;
							d = ad * (bn < 0 ? -bn : bn);
							r = reduce(neg, n, d);
						end
					end
					default: begin
						p = an * bd;
						q = bn * ad;
						r.cmp = p < q ? rau_pkg::CMP_LESS :
							(p == q ? rau_pkg::CMP_EQUAL : rau_pkg::CMP_GREATER);
					end
				endcase
			end
		end
		pending.push_back(r);
	endfunction

	function void check_result(logic [63:0] data, logic [3:0] user);
		frac_result_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result beat %h %h", data, user);
			return;
		end
		e = pending.pop_front();
		if (data[31:0] !== e.num || data[62:32] !== e.den || data[63] !== 1'b0 ||
				user[1:0] !== e.cmp || user[3:2] !== e.status) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected num %0d den %0d cmp %0d st %0d, got %h %h",
					$signed(e.num), e.den, e.cmp, e.status, data, user);
		end
	endfunction
endclass

module rational_arithmetic_unit_test;
	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [63:0]  m_axis_tdata;
	logic [3:0]   m_axis_tuser;

	fraction_scoreboard fractions = new();
	bit  sending_done = 0;
	bit  hold_off = 0;
	int  idle_cycles = 0;
	localparam int IDLE_LIMIT = 20000;

	rational_arithmetic_unit dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function int gap_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 300) : $urandom_range(0, 3);
	endfunction

	// Offer one operand beat after a random gap and wait for its acceptance.
	// The valid stays high afterwards; a gap or the caller drops it.
	task automatic send_operands(logic [2:0] mode, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd, bit no_gap);
		int gap;
		gap = no_gap ? 0 : gap_length();
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {bd, bn, ad, an};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		fractions.note_operands(mode, {bd, bn, ad, an});
	endtask

	function logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return $urandom_range(0, 2000) - 1000;
			2: return $urandom_range(0, 131072) - 65536;
			3: return $urandom() & 32'h0000_FFFF | ($urandom_range(0, 1) ? 32'hFFFF_0000 : 0);
			default: return $urandom();
		endcase
	endfunction

	// Receiver: random stalls, with one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_axis_tready <= 0;
				repeat (2000) @(posedge clk);
				hold_off = 0;
			end
			gap = gap_length();
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
		end
	end

	// Collect result beats.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			fractions.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [31:0] mn, mx;
		int k;
		mn = 32'h8000_0000;
		mx = 32'h7FFF_FFFF;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: each operation, zero denominators, divide by zero,
		// overflow, zero result, extreme operands and unused modes.
		send_operands(rau_pkg::OP_ADD, 1, 2, 1, 3, 0);
		send_operands(rau_pkg::OP_SUB, 1, 2, 1, 2, 0);
		send_operands(rau_pkg::OP_MUL, -3, 4, 8, -9, 0);
		send_operands(rau_pkg::OP_DIV, 2, 3, -4, 5, 0);
		send_operands(rau_pkg::OP_CMP, 1, 3, 1, 2, 0);
		send_operands(rau_pkg::OP_CMP, 2, 4, 1, 2, 0);
		send_operands(rau_pkg::OP_CMP, mx, 1, mn, 1, 0);
		send_operands(rau_pkg::OP_ADD, 1, 0, 1, 1, 0);
		send_operands(rau_pkg::OP_CMP, 1, 1, 1, 0, 0);
		send_operands(rau_pkg::OP_DIV, 1, 1, 0, 5, 0);
		send_operands(rau_pkg::OP_ADD, mx, 1, mx, 1, 0);
		send_operands(rau_pkg::OP_MUL, mn, 1, mn, 1, 0);
		send_operands(rau_pkg::OP_MUL, mn, 1, 1, 1, 0);
		send_operands(rau_pkg::OP_DIV, mn, 1, -1, 1, 0);
		send_operands(rau_pkg::OP_MUL, 1, mn, 1, -1, 0);
		send_operands(rau_pkg::OP_DIV, 1, mx, mx, 1, 0);
		send_operands(rau_pkg::OP_ADD, mn, mn, mx, mx, 0);
		send_operands(rau_pkg::OP_SUB, mn, mx, mn, mx, 0);
		send_operands(rau_pkg::OP_DIV, mx, mn, mn, mx, 0);
		send_operands(3'd5, 1, 1, 1, 1, 0);
		send_operands(3'd7, mn, 0, mx, 0, 0);

		// Fill the block while the receiver holds off.
		hold_off = 1;
		for (k = 0; k < 10; k++)
			send_operands(rau_pkg::OP_MUL, rand_value(), rand_value() | 1, rand_value(), 7, 1);

		for (k = 0; k < 1000; k++) begin
			if (k == 500) begin
				// Pause until every result has been delivered.
				s_axis_tvalid <= 0;
				while (fractions.pending.size() != 0) @(posedge clk);
			end
			send_operands($urandom_range(0, 19) == 0 ? $urandom_range(5, 7) : $urandom_range(0, 4),
				rand_value(), $urandom_range(0, 30) == 0 ? 0 : rand_value(),
				$urandom_range(0, 20) == 0 ? 0 : rand_value(),
				$urandom_range(0, 30) == 0 ? 0 : rand_value(), 0);
		end
		s_axis_tvalid <= 0;

		while (fractions.pending.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (fractions.mismatches == 0 && fractions.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
